[design/ring_walker_trap_food_step_macros.svh]
// assertion macros for the ring walker block
`ifndef RING_WALKER_TRAP_FOOD_STEP_MACROS_SVH
`define RING_WALKER_TRAP_FOOD_STEP_MACROS_SVH

// same-cycle implication
`define RWTF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RWTF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/rwtf_pkg.sv]
// shared codes for the ring walker block
`default_nettype none
package rwtf_pkg;
    typedef logic [1:0] t_action;
    localparam t_action ACT_LOAD  = 2'd0;
    localparam t_action ACT_PLACE = 2'd1;
    localparam t_action ACT_STEP  = 2'd2;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_RING_SIZE    = 2'd0;
    localparam t_cfg_index CFG_SHARED_SITES = 2'd1;
    localparam t_cfg_index CFG_FOOD_ENABLED = 2'd2;

    localparam int COUNT_BITS = 9;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 9'd511;
    localparam int RING_BITS = 11;
endpackage
`default_nettype wire

[design/rwtf_ram.sv]
// single write port, single registered read port memory
`default_nettype none
module rwtf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 41
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/ring_walker_trap_food_step.sv]
// top level: ring walker sequencer over the site and walker memories
`default_nettype none
`include "ring_walker_trap_food_step_macros.svh"
// Each item runs read-modify-write passes over two memories, one of sites
// (trap time, food, occupancy count) and one of walkers. An accepted item
// enters FETCH; a load, a refused placement or an ignored item goes on to
// OUT, a placement that moves the walker off another site passes through
// PLACE_RD and PLACE_WR, a step of a dead walker through DEAD_RD and any
// other step through CUR and DST, then OUT and back to IDLE. The order is
// set by the single read and single write port of the site memory:
// current site and destination site are read one after the other. The
// result sits in an output register, so the next item is taken while it
// waits; only a following result that finds that register still stalled
// holds the block in its last state. After reset a clearing pass over
// max(MAX_SITES, MAX_WALKERS) addresses zeroes both memories; no item is
// accepted meanwhile, configuration writes are taken at any time.
module ring_walker_trap_food_step #(
    parameter int MAX_SITES   = 1024,
    parameter int MAX_WALKERS = 256,
    parameter int FOOD_BITS   = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire rwtf_pkg::t_action   i_action,
    input  wire logic [9:0]          i_site_index,
    input  wire logic [7:0]          i_walker_index,
    input  wire logic [15:0]         i_trap_length,
    input  wire logic [15:0]         i_food_amount,
    input  wire logic [15:0]         i_eat_amount,
    input  wire logic                i_go_left,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [9:0]               o_position,
    output logic                     o_held,
    output logic                     o_died,
    output logic [15:0]              o_food_left,
    output logic                     o_accepted,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire rwtf_pkg::t_cfg_index i_cfg_index,
    input  wire logic [10:0]         i_cfg_data
);
    import rwtf_pkg::*;

    localparam int SA = $clog2(MAX_SITES);
    localparam int WA = (MAX_WALKERS > 1) ? $clog2(MAX_WALKERS) : 1;
    localparam int RW = $clog2(MAX_SITES + 1);
    localparam int CW = (RW > RING_BITS) ? RW : RING_BITS;
    localparam int K  = (MAX_SITES > MAX_WALKERS) ? MAX_SITES : MAX_WALKERS;
    localparam int KA = $clog2(K);

    localparam logic [3:0] ST_CLR      = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_FETCH    = 4'd2;
    localparam logic [3:0] ST_PLACE_RD = 4'd3;
    localparam logic [3:0] ST_PLACE_WR = 4'd4;
    localparam logic [3:0] ST_DEAD_RD  = 4'd5;
    localparam logic [3:0] ST_CUR      = 4'd6;
    localparam logic [3:0] ST_DST      = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    typedef struct packed {
        logic [15:0]           trap;
        logic [FOOD_BITS-1:0]  food;
        logic [COUNT_BITS-1:0] count;
    } t_site;

    typedef struct packed {
        logic                 live;
        logic                 dead;
        logic                 trapped;
        logic [15:0]          hold;
        logic [FOOD_BITS-1:0] eat;
        logic [SA-1:0]        pos;
    } t_walk;

    function automatic logic [COUNT_BITS-1:0] cnt_up(input logic [COUNT_BITS-1:0] c);
        cnt_up = (c < COUNT_MAX) ? c + 1'b1 : c;
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_down(input logic [COUNT_BITS-1:0] c);
        cnt_down = (c != '0) ? c - 1'b1 : c;
    endfunction

    logic [3:0]            r_state, n_state;
    logic [KA-1:0]         r_clr, n_clr;
    logic [10:0]           r_ring_size;
    logic                  r_shared, r_food_en;

    t_action               r_act;
    logic [9:0]            r_s;
    logic [7:0]            r_w;
    logic [15:0]           r_trap;
    logic [FOOD_BITS-1:0]  r_food, r_eat;
    logic                  r_left;

    t_walk                 r_wk, n_wk;
    t_site                 r_cur, n_cur, r_dst, n_dst;
    logic [SA-1:0]         r_cur_a, n_cur_a, r_dst_a, n_dst_a;
    logic                  r_move, n_move;

    logic [9:0]            r_rp, n_rp;
    logic                  r_rh, n_rh, r_rd, n_rd, r_ra, n_ra;
    logic [15:0]           r_rf, n_rf;
    logic                  r_ov, n_ov;
    logic [9:0]            r_op, n_op;
    logic                  r_oh, n_oh, r_odi, n_odi, r_oa, n_oa;
    logic [15:0]           r_of, n_of;

    logic                  site_we, walk_we;
    logic [SA-1:0]         site_waddr, site_raddr;
    logic [WA-1:0]         walk_waddr, walk_raddr;
    t_site                 site_wdata, site_q;
    t_walk                 walk_wdata, walk_q;
    logic [$bits(t_site)-1:0] site_rdata;
    logic [$bits(t_walk)-1:0] walk_rdata;

    logic [CW-1:0]         ring_n, cur_c, dst_c;
    logic [SA-1:0]         s_site;
    logic                  s_ok, w_ok, in_acc;
    logic [COUNT_BITS-1:0] others;
    t_site                 d_e, fin;
    logic [SA-1:0]         fin_a;
    logic                  blocked, dead_n, trap_n;
    logic [15:0]           hold_n;

    rwtf_ram #(.DEPTH(MAX_SITES), .WIDTH($bits(t_site))) u_site_mem (
        .i_clk   (i_clk),
        .i_we    (site_we),
        .i_waddr (site_waddr),
        .i_wdata (site_wdata),
        .i_raddr (site_raddr),
        .o_rdata (site_rdata)
    );

    rwtf_ram #(.DEPTH(MAX_WALKERS), .WIDTH($bits(t_walk))) u_walk_mem (
        .i_clk   (i_clk),
        .i_we    (walk_we),
        .i_waddr (walk_waddr),
        .i_wdata (walk_wdata),
        .i_raddr (walk_raddr),
        .o_rdata (walk_rdata)
    );

    assign site_q      = t_site'(site_rdata);
    assign walk_q      = t_walk'(walk_rdata);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_position  = r_op;
    assign o_held      = r_oh;
    assign o_died      = r_odi;
    assign o_food_left = r_of;
    assign o_accepted  = r_oa;

    assign s_site = SA'(r_s);
    assign s_ok   = (32'(r_s) < MAX_SITES);
    assign w_ok   = (32'(r_w) < MAX_WALKERS);
    assign ring_n = (r_ring_size == '0) ? CW'(1) :
                    ((CW'(r_ring_size) > CW'(MAX_SITES)) ? CW'(MAX_SITES) : CW'(r_ring_size));

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_wk    = r_wk;
        n_cur   = r_cur;
        n_dst   = r_dst;
        n_cur_a = r_cur_a;
        n_dst_a = r_dst_a;
        n_move  = r_move;
        n_rp = r_rp; n_rh = r_rh; n_rd = r_rd; n_rf = r_rf; n_ra = r_ra;
        n_op = r_op; n_oh = r_oh; n_odi = r_odi; n_of = r_of; n_oa = r_oa;
        n_ov = r_ov && i_out_stall;
        site_we    = 1'b0;
        site_waddr = r_cur_a;
        site_wdata = r_cur;
        site_raddr = r_cur_a;
        walk_we    = 1'b0;
        walk_waddr = WA'(r_w);
        walk_wdata = r_wk;
        walk_raddr = WA'(r_w);
        others  = '0;
        d_e     = site_q;
        fin     = r_cur;
        fin_a   = r_cur_a;
        blocked = 1'b0;
        dead_n  = 1'b0;
        trap_n  = 1'b0;
        hold_n  = r_wk.hold;
        cur_c   = CW'(r_cur_a);
        dst_c   = '0;

        case (r_state)
            ST_CLR: begin
                site_we    = (32'(r_clr) < MAX_SITES);
                site_waddr = SA'(r_clr);
                site_wdata = '0;
                walk_we    = (32'(r_clr) < MAX_WALKERS);
                walk_waddr = WA'(r_clr);
                walk_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == KA'(K - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                site_raddr = SA'(i_site_index);
                walk_raddr = WA'(i_walker_index);
                if (in_acc) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_wk = walk_q;
                n_rp = r_s; n_rh = 1'b0; n_rd = 1'b0; n_rf = '0; n_ra = 1'b0;
                n_state = ST_OUT;
                case (r_act)
                    ACT_LOAD: begin
                        if (s_ok) begin
                            site_we    = 1'b1;
                            site_waddr = s_site;
                            site_wdata = '{trap: r_trap, food: r_food, count: site_q.count};
                            n_rf = 16'(r_food);
                            n_ra = 1'b1;
                        end
                    end
                    ACT_PLACE: begin
                        others = site_q.count;
                        if (walk_q.live && walk_q.pos == s_site && site_q.count != '0) begin
                            others = site_q.count - 1'b1;
                        end
                        if (!w_ok || CW'(r_s) >= ring_n) begin
                            n_rf = s_ok ? 16'(site_q.food) : 16'd0;
                        end else if (!r_shared && others != '0) begin
                            n_rf = 16'(site_q.food);
                        end else if (walk_q.live && walk_q.pos != s_site) begin
                            n_dst      = site_q;
                            site_raddr = walk_q.pos;
                            n_state    = ST_PLACE_RD;
                        end else begin
                            site_we    = 1'b1;
                            site_waddr = s_site;
                            site_wdata = site_q;
                            site_wdata.count = cnt_up(walk_q.live ? cnt_down(site_q.count)
                                                                  : site_q.count);
                            walk_we    = 1'b1;
                            walk_wdata = '{live: 1'b1, dead: 1'b0, trapped: 1'b0,
                                           hold: 16'd0, eat: r_eat, pos: s_site};
                            n_rf = 16'(site_q.food);
                            n_ra = 1'b1;
                        end
                    end
                    ACT_STEP: begin
                        n_rp = '0;
                        if (w_ok && walk_q.live) begin
                            site_raddr = walk_q.pos;
                            n_cur_a    = walk_q.pos;
                            n_state    = walk_q.dead ? ST_DEAD_RD : ST_CUR;
                        end
                    end
                    default: begin
                        n_rp = '0;
                    end
                endcase
            end
            ST_PLACE_RD: begin
                site_we    = 1'b1;
                site_waddr = r_wk.pos;
                site_wdata = site_q;
                site_wdata.count = cnt_down(site_q.count);
                n_state    = ST_PLACE_WR;
            end
            ST_PLACE_WR: begin
                site_we    = 1'b1;
                site_waddr = s_site;
                site_wdata = r_dst;
                site_wdata.count = cnt_up(r_dst.count);
                walk_we    = 1'b1;
                walk_wdata = '{live: 1'b1, dead: 1'b0, trapped: 1'b0,
                               hold: 16'd0, eat: r_eat, pos: s_site};
                n_rf = 16'(r_dst.food);
                n_ra = 1'b1;
                n_state = ST_OUT;
            end
            ST_DEAD_RD: begin
                n_rp = 10'(r_wk.pos); n_rh = r_wk.trapped; n_rd = 1'b1;
                n_rf = 16'(site_q.food); n_ra = 1'b1;
                n_state = ST_OUT;
            end
            ST_CUR: begin
                trap_n = 1'b0;
                hold_n = r_wk.hold;
                if (site_q.trap != '0) begin
                    if (!r_wk.trapped) begin
                        trap_n = 1'b1;
                        hold_n = site_q.trap;
                    end else if (r_wk.hold <= 16'd1) begin
                        trap_n = 1'b0;
                    end else begin
                        trap_n = 1'b1;
                        hold_n = r_wk.hold - 1'b1;
                    end
                end
                n_wk.trapped = trap_n;
                n_wk.hold    = hold_n;
                n_cur  = site_q;
                n_move = !trap_n;
                if (r_left) begin
                    dst_c = (cur_c == '0 || cur_c >= ring_n) ? ring_n - 1'b1 : cur_c - 1'b1;
                end else begin
                    dst_c = (cur_c + 1'b1 >= ring_n) ? '0 : cur_c + 1'b1;
                end
                n_dst_a    = SA'(dst_c);
                site_raddr = SA'(dst_c);
                if (!trap_n) begin
                    n_cur.count = cnt_down(site_q.count);
                    site_we     = 1'b1;
                    site_waddr  = r_cur_a;
                    site_wdata  = n_cur;
                end
                n_state = ST_DST;
            end
            ST_DST: begin
                if (r_move) begin
                    d_e     = (r_dst_a == r_cur_a) ? r_cur : site_q;
                    blocked = !r_shared && d_e.count != '0;
                    fin_a   = blocked ? r_cur_a : r_dst_a;
                    fin     = blocked ? r_cur : d_e;
                    fin.count = cnt_up(fin.count);
                end
                if (r_food_en) begin
                    if (fin.food >= r_wk.eat) begin
                        fin.food = fin.food - r_wk.eat;
                    end else begin
                        fin.food = '0;
                        dead_n   = 1'b1;
                    end
                end
                site_we    = 1'b1;
                site_waddr = fin_a;
                site_wdata = fin;
                walk_we    = 1'b1;
                walk_wdata = r_wk;
                walk_wdata.pos  = fin_a;
                walk_wdata.dead = dead_n;
                n_rp = 10'(fin_a); n_rh = r_wk.trapped; n_rd = dead_n;
                n_rf = 16'(fin.food); n_ra = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov  = 1'b1;
                    n_op  = r_rp; n_oh = r_rh; n_odi = r_rd; n_of = r_rf; n_oa = r_ra;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_ov        <= 1'b0;
            r_ring_size <= 11'd1024;
            r_shared    <= 1'b1;
            r_food_en   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RING_SIZE:    r_ring_size <= i_cfg_data;
                    CFG_SHARED_SITES: r_shared    <= i_cfg_data[0];
                    CFG_FOOD_ENABLED: r_food_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act  <= i_action;
            r_s    <= i_site_index;
            r_w    <= i_walker_index;
            r_trap <= i_trap_length;
            r_food <= FOOD_BITS'(i_food_amount);
            r_eat  <= FOOD_BITS'(i_eat_amount);
            r_left <= i_go_left;
        end
        r_wk    <= n_wk;
        r_cur   <= n_cur;
        r_dst   <= n_dst;
        r_cur_a <= n_cur_a;
        r_dst_a <= n_dst_a;
        r_move  <= n_move;
        r_rp <= n_rp; r_rh <= n_rh; r_rd <= n_rd; r_rf <= n_rf; r_ra <= n_ra;
        r_op <= n_op; r_oh <= n_oh; r_odi <= n_odi; r_of <= n_of; r_oa <= n_oa;
    end

    `RWTF_ASSERT_NEXT(a_accept_fetch, i_clk, i_rst_n, in_acc, r_state == ST_FETCH)
    `RWTF_ASSERT_NOW(a_idle_no_write, i_clk, i_rst_n, r_state == ST_IDLE, !site_we && !walk_we)
    `RWTF_ASSERT_NEXT(a_out_wait, i_clk, i_rst_n, r_state == ST_OUT && r_ov && i_out_stall, r_state == ST_OUT)
endmodule
`default_nettype wire
